>>> hdl/pskps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pskps_pkg;

  localparam int STORE_DEPTH = 256;
  localparam int VAL_W       = 8;
  localparam int CNT_W       = 9;
  localparam int CFG_IDX_W   = 2;

  typedef logic [VAL_W-1:0]     val_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_SET_SIZE   = cfg_idx_t'(0);
  localparam cfg_idx_t REG_DRAW_COUNT = cfg_idx_t'(1);

  localparam cnt_t SET_MAX = cnt_t'(STORE_DEPTH);

endpackage
`default_nettype wire

>>> hdl/pskps_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
interface pskps_in_if;
  import pskps_pkg::*;
  logic valid;
  logic ready;
  val_t offset;
  modport source (output valid, output offset, input ready);
  modport sink (input valid, input offset, output ready);
endinterface

interface pskps_out_if;
  import pskps_pkg::*;
  logic valid;
  logic ready;
  val_t value;
  logic last;
  logic error;
  modport source (output valid, output value, output last, output error, input ready);
  modport sink (input valid, input value, input last, input error, output ready);
endinterface

interface pskps_cfg_if;
  import pskps_pkg::*;
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  cnt_t     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> hdl/partial_shuffle_k_permutation_sampler_top.sv
// path: an accepted draw is registered in stage 1, then in the result register, which drives draw_out
// throughput: one draw per cycle while the result side keeps up
// the rate is set by the two-read, one-write store with a one-deep write bypass
// reset: position 0, set size and draw count 1, all written marks cleared,
// pipeline and result register empty; store contents undefined until written
`timescale 1ns / 1ps
`default_nettype none
module partial_shuffle_k_permutation_sampler_top (
  input wire logic   clk,
  input wire logic   rst,
  pskps_in_if.sink   draw_in,
  pskps_out_if.source draw_out,
  pskps_cfg_if.sink  cfg
);
  import pskps_pkg::*;

  cnt_t set_size;
  cnt_t draw_count;
  cnt_t position;
  logic [STORE_DEPTH-1:0] marks;
  logic [STORE_DEPTH-1:0] marks_next;

  // stage 1
  logic s1_valid;
  logic s1_err;
  logic s1_last;
  val_t s1_idx;
  val_t s1_pos;
  logic s1_mark_i;
  logic s1_mark_p;
  logic s1_fwd_i;
  logic s1_fwd_p;
  val_t s1_fwd_data;

  // result register
  logic out_valid;
  val_t out_value;
  logic out_last;
  logic out_error;

  cnt_t n_eff;
  cnt_t k_eff;
  cnt_t pos_eff;
  cnt_t room;
  logic in_err;
  logic in_last;
  val_t in_pos;
  val_t in_idx;
  logic in_mark_i;
  logic in_mark_p;
  logic accept;
  logic s1_adv;
  logic wr_en;
  val_t ram_a;
  val_t ram_b;
  val_t rd_i;
  val_t rd_p;
  val_t drawn;
  val_t moved;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size   <= cnt_t'(1);
      draw_count <= cnt_t'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SET_SIZE:   set_size   <= cfg.data;
        REG_DRAW_COUNT: draw_count <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    n_eff = set_size;
    if (set_size == '0) n_eff = cnt_t'(1);
    if (set_size > SET_MAX) n_eff = SET_MAX;
    k_eff = draw_count;
    if (draw_count == '0) k_eff = cnt_t'(1);
    if (k_eff > n_eff) k_eff = n_eff;
    pos_eff = (position >= k_eff) ? '0 : position;
    room    = n_eff - pos_eff;
    in_err  = cnt_t'(draw_in.offset) >= room;
    in_last = (pos_eff + cnt_t'(1)) == k_eff;
    in_pos  = pos_eff[VAL_W-1:0];
    in_idx  = in_pos + draw_in.offset;
    in_mark_i = (pos_eff != '0) && marks[in_idx];
    in_mark_p = (pos_eff != '0) && marks[in_pos];
    marks_next = marks;
    if (pos_eff == '0) begin
      marks_next = '0;
    end
    marks_next[in_idx] = 1'b1;
  end

  assign s1_adv        = s1_valid && (!out_valid || draw_out.ready);
  assign draw_in.ready = !s1_valid || s1_adv;
  assign accept        = draw_in.valid && draw_in.ready;
  assign wr_en         = s1_adv && !s1_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      marks    <= '0;
    end else if (accept && !in_err) begin
      position <= in_last ? '0 : pos_eff + cnt_t'(1);
      marks    <= marks_next;
    end
  end

  pskps_ram #(
    .WIDTH (VAL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (s1_idx),
    .wdata   (moved),
    .re      (accept),
    .raddr_a (in_idx),
    .raddr_b (in_pos),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  always_comb begin
    rd_i  = s1_fwd_i ? s1_fwd_data : ram_a;
    rd_p  = s1_fwd_p ? s1_fwd_data : ram_b;
    drawn = s1_mark_i ? rd_i : s1_idx;
    moved = s1_mark_p ? rd_p : s1_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err      <= in_err;
      s1_last     <= in_last;
      s1_idx      <= in_idx;
      s1_pos      <= in_pos;
      s1_mark_i   <= in_mark_i;
      s1_mark_p   <= in_mark_p;
      // bypass the write that lands on the same edge as these reads
      s1_fwd_i    <= wr_en && (in_idx == s1_idx);
      s1_fwd_p    <= wr_en && (in_pos == s1_idx);
      s1_fwd_data <= moved;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (draw_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_value <= s1_err ? '0 : drawn;
      out_last  <= !s1_err && s1_last;
      out_error <= s1_err;
    end
  end

  assign draw_out.valid = out_valid;
  assign draw_out.value = out_value;
  assign draw_out.last  = out_last;
  assign draw_out.error = out_error;

endmodule
`default_nettype wire

>>> hdl/pskps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module pskps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

>>> verif/tb_partial_shuffle_k_permutation_sampler_top.sv
`timescale 1ns / 1ps
module tb_partial_shuffle_k_permutation_sampler_top;
  import pskps_pkg::*;

  localparam int RAND_ITEMS     = 1250;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRESSURE_PHASE = 2;

  localparam cfg_idx_t REG_UNMAPPED_LO = cfg_idx_t'(2);
  localparam cfg_idx_t REG_UNMAPPED_HI = cfg_idx_t'(3);

  typedef struct packed {
    val_t value;
    logic last;
    logic error;
  } draw_res_t;

  typedef enum logic {ROW_DRAW, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    cfg_idx_t  idx;
    cnt_t      data;
    val_t      off;
    logic      typed;
    draw_res_t res;
  } row_t;

  localparam draw_res_t NO_RES = '0;

  localparam row_t DIRECTED [33] = '{
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(0),   1'b1, '{val_t'(0), 1'b1, 1'b0}},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(255), 1'b1, '{val_t'(0), 1'b0, 1'b1}},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(1),   1'b1, '{val_t'(0), 1'b0, 1'b1}},
    '{ROW_WRITE, REG_SET_SIZE,    cnt_t'(0),   val_t'(0),   1'b0, NO_RES},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(0),   1'b1, '{val_t'(0), 1'b1, 1'b0}},
    '{ROW_WRITE, REG_SET_SIZE,    cnt_t'(511), val_t'(0),   1'b0, NO_RES},
    '{ROW_WRITE, REG_DRAW_COUNT,  cnt_t'(0),   val_t'(0),   1'b0, NO_RES},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(255), 1'b1, '{val_t'(255), 1'b1, 1'b0}},
    '{ROW_WRITE, REG_DRAW_COUNT,  cnt_t'(511), val_t'(0),   1'b0, NO_RES},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(255), 1'b1, '{val_t'(255), 1'b0, 1'b0}},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(255), 1'b1, '{val_t'(0), 1'b0, 1'b1}},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(254), 1'b0, NO_RES},
    '{ROW_WRITE, REG_DRAW_COUNT,  cnt_t'(2),   val_t'(0),   1'b0, NO_RES},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(0),   1'b1, '{val_t'(0), 1'b0, 1'b0}},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(0),   1'b1, '{val_t'(1), 1'b1, 1'b0}},
    '{ROW_WRITE, REG_UNMAPPED_LO, cnt_t'(511), val_t'(0),   1'b0, NO_RES},
    '{ROW_WRITE, REG_UNMAPPED_HI, cnt_t'(170), val_t'(0),   1'b0, NO_RES},
    '{ROW_WRITE, REG_SET_SIZE,    cnt_t'(2),   val_t'(0),   1'b0, NO_RES},
    '{ROW_WRITE, REG_DRAW_COUNT,  cnt_t'(3),   val_t'(0),   1'b0, NO_RES},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(1),   1'b0, NO_RES},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(0),   1'b0, NO_RES},
    '{ROW_WRITE, REG_SET_SIZE,    cnt_t'(5),   val_t'(0),   1'b0, NO_RES},
    '{ROW_WRITE, REG_DRAW_COUNT,  cnt_t'(5),   val_t'(0),   1'b0, NO_RES},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(4),   1'b0, NO_RES},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(4),   1'b0, NO_RES},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(3),   1'b0, NO_RES},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(2),   1'b0, NO_RES},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(1),   1'b0, NO_RES},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(0),   1'b0, NO_RES},
    '{ROW_WRITE, REG_SET_SIZE,    cnt_t'(256), val_t'(0),   1'b0, NO_RES},
    '{ROW_WRITE, REG_DRAW_COUNT,  cnt_t'(1),   val_t'(0),   1'b0, NO_RES},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(0),   1'b1, '{val_t'(0), 1'b1, 1'b0}},
    '{ROW_DRAW,  REG_SET_SIZE,    cnt_t'(0),   val_t'(128), 1'b1, '{val_t'(128), 1'b1, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst;

  pskps_in_if  draw_in ();
  pskps_out_if draw_out ();
  pskps_cfg_if cfg ();

  partial_shuffle_k_permutation_sampler_top dut (
    .clk      (clk),
    .rst      (rst),
    .draw_in  (draw_in),
    .draw_out (draw_out),
    .cfg      (cfg)
  );

  always #1 clk = ~clk;

  // shadow of the sampler state
  cnt_t set_size_q;
  cnt_t draw_count_q;
  cnt_t pos_q;
  val_t perm_q [STORE_DEPTH];
  bit   mark_q [STORE_DEPTH];

  draw_res_t pending_draws [$];

  bit quiet;
  bit hold_req;
  int err_count;
  int results_seen;
  int draws_sent;
  int oor_sent;
  int closed_runs;
  int settings_used;
  int idle_cycles;

  function automatic int eff_set();
    int n;
    n = int'(set_size_q);
    if (n == 0) n = 1;
    if (n > STORE_DEPTH) n = STORE_DEPTH;
    return n;
  endfunction

  function automatic int eff_draws(input int n);
    int k;
    k = int'(draw_count_q);
    if (k == 0) k = 1;
    if (k > n) k = n;
    return k;
  endfunction

  function automatic int span_left();
    int n;
    int k;
    int p;
    n = eff_set();
    k = eff_draws(n);
    p = int'(pos_q);
    if (p >= k) p = 0;
    return n - p;
  endfunction

  function automatic draw_res_t shuffle_step(input val_t off);
    int n;
    int k;
    int p;
    int idx;
    draw_res_t r;
    n = eff_set();
    k = eff_draws(n);
    p = int'(pos_q);
    if (p >= k) p = 0;
    r = '0;
    if (int'(off) >= n - p) begin
      r.error = 1'b1;
      return r;
    end
    // a draw at position zero opens a new realization
    if (p == 0) mark_q = '{default: 1'b0};
    idx = p + int'(off);
    r.value = mark_q[idx] ? perm_q[idx] : val_t'(idx);
    perm_q[idx] = mark_q[p] ? perm_q[p] : val_t'(p);
    mark_q[idx] = 1'b1;
    r.last = (p + 1 == k);
    pos_q = r.last ? cnt_t'(0) : cnt_t'(p + 1);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    err_count++;
    $display("mismatch on %s at result %0d: got %0d, want %0d",
             field, results_seen, got, want);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input cnt_t data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    if (idx == REG_SET_SIZE) set_size_q = data;
    else if (idx == REG_DRAW_COUNT) draw_count_q = data;
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic push_draw(input val_t off, input bit typed, input draw_res_t typed_res);
    int gap;
    draw_res_t r;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      draw_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    draw_in.valid  <= 1'b1;
    draw_in.offset <= off;
    do @(posedge clk); while (!draw_in.ready);
    r = shuffle_step(off);
    draws_sent++;
    if (r.error) oor_sent++;
    if (r.last) closed_runs++;
    pending_draws.push_back(typed ? typed_res : r);
  endtask

  task automatic wait_idle();
    draw_in.valid <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : result_sink
    int gap;
    draw_res_t got;
    draw_res_t want;
    draw_out.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 15);
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        draw_out.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      draw_out.ready <= 1'b1;
      do @(posedge clk); while (!draw_out.valid);
      got.value = draw_out.value;
      got.last  = draw_out.last;
      got.error = draw_out.error;
      if (pending_draws.size() == 0) begin
        report_mismatch("unexpected transfer", int'(got), -1);
      end else begin
        want = pending_draws.pop_front();
        if (got.value !== want.value) report_mismatch("value", got.value, want.value);
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
        if (got.error !== want.error) report_mismatch("error", got.error, want.error);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if ((draw_in.valid && draw_in.ready) || (draw_out.valid && draw_out.ready) ||
        (cfg.valid && cfg.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_partial_shuffle_k_permutation_sampler_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int rand_items;
    int phase;
    int n_set;
    int k_set;
    int ne;
    int ke;
    int len;
    val_t off;
    rst            <= 1'b1;
    draw_in.valid  <= 1'b0;
    draw_in.offset <= '0;
    cfg.valid      <= 1'b0;
    cfg.index      <= '0;
    cfg.data       <= '0;
    set_size_q     = cnt_t'(1);
    draw_count_q   = cnt_t'(1);
    pos_q          = '0;
    perm_q         = '{default: '0};
    mark_q         = '{default: 1'b0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        push_draw(DIRECTED[i].off, DIRECTED[i].typed, DIRECTED[i].res);
      end
    end

    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0: n_set = $urandom_range(0, 1);
        1: n_set = $urandom_range(257, 511);
        2: n_set = 256;
        default: n_set = $urandom_range(1, 16);
      endcase
      ne = (n_set == 0) ? 1 : ((n_set > STORE_DEPTH) ? STORE_DEPTH : n_set);
      case ($urandom_range(0, 7))
        0: k_set = 0;
        1: k_set = $urandom_range(ne + 1, 511);
        2: k_set = ne;
        default: k_set = $urandom_range(1, ne);
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      if (phase == PRESSURE_PHASE) begin
        n_set = 16;
        k_set = 8;
        ne = 16;
        quiet = 1'b1;
      end
      if ($urandom_range(0, 1)) begin
        write_reg(REG_SET_SIZE, cnt_t'(n_set));
        write_reg(REG_DRAW_COUNT, cnt_t'(k_set));
      end else begin
        write_reg(REG_DRAW_COUNT, cnt_t'(k_set));
        write_reg(REG_SET_SIZE, cnt_t'(n_set));
      end
      if ($urandom_range(0, 7) == 0)
        write_reg($urandom_range(0, 1) ? REG_UNMAPPED_LO : REG_UNMAPPED_HI,
                  cnt_t'($urandom_range(0, 511)));
      settings_used++;
      ke = (k_set == 0) ? 1 : ((k_set > ne) ? ne : k_set);
      len = $urandom_range(20, 60);
      if (ke > 60 && $urandom_range(0, 2) == 0) len = ke + $urandom_range(0, 10);
      if (len > RAND_ITEMS - rand_items) len = RAND_ITEMS - rand_items;
      // receiver stalls long while the input keeps offering
      if (phase == PRESSURE_PHASE) hold_req = 1'b1;
      for (int j = 0; j < len; j++) begin
        if ($urandom_range(0, 9) == 0) off = val_t'($urandom_range(0, 255));
        else off = val_t'($urandom_range(0, span_left() - 1));
        push_draw(off, 1'b0, NO_RES);
        rand_items++;
      end
      quiet = 1'b0;
      phase++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("%0d draws sent, %0d out of range, %0d realizations closed, %0d register settings",
             draws_sent, oor_sent, closed_runs, settings_used);
    $display("%0d results checked, %0d mismatches", results_seen, err_count);
    if (err_count == 0 && pending_draws.size() == 0)
      $display("tb_partial_shuffle_k_permutation_sampler_top: done, clean");
    else
      $display("tb_partial_shuffle_k_permutation_sampler_top: done, errors");
    $finish;
  end

endmodule
